// ----- rtl/pmc_pkg.sv -----
// Package for the point motion classifier: sizes, register indexes and handshake structs.
`timescale 1ns / 1ps
package pmc_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int COORD_W    = 20;
    localparam int CFG_W      = 16;
    localparam int TALLY_W    = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W     = IDX_W + 1;
    localparam int STORE_D    = 2 * MAX_POINTS;
    localparam int ENTRY_W    = 6 * COORD_W;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W + 1;
    localparam int SUM_W      = SQ_W + 2;
    localparam int DIV_STEPS  = COORD_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS);
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 96;

    // Cells count as neighbors when they differ by at most this much.
    localparam int CELL_REACH = 1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CELL_SIZE   = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD   = 2'd1;
    localparam logic [1:0] CFG_FILTER_EN   = 2'd2;
    localparam logic [1:0] CFG_KEEP_STATIC = 2'd3;

    localparam logic [CFG_W-1:0]   RST_CELL_SIZE = 16'd200;
    localparam logic [CFG_W-1:0]   RST_THRESHOLD = 16'd100;
    localparam logic [TALLY_W-1:0] TALLY_MAX     = '1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic fix;
        logic issue;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic do_scan;
        logic scan_last;
        logic pipe_busy;
    } t_sts;

endpackage

// ----- rtl/pmc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module pmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pmc_ctrl.sv -----
// Controller state machine that sequences division, history scan and result commit.
`timescale 1ns / 1ps
module pmc_ctrl import pmc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_FIX   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = i_sts.do_scan ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The output register empties on a taken request and fills on commit.
    always_comb begin
        n_out_valid = r_out_valid && !i_m_tready;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

// ----- rtl/pmc_dp.sv -----
// Datapath: configuration, cell divider, history compare pipeline, tallies and result register.
`timescale 1ns / 1ps
module pmc_dp import pmc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tlast,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast
);

    localparam logic [CNT_W-1:0]  FILL_FULL = CNT_W'(MAX_POINTS);
    localparam logic [DCNT_W-1:0] DIV_LAST  = DCNT_W'(DIV_STEPS - 1);
    localparam logic signed [DIFF_W-1:0] REACH = DIFF_W'(CELL_REACH);

    // Configuration registers.
    logic [CFG_W-1:0] r_cell_size, r_threshold;
    logic             r_filter_en, r_keep_static;
    logic [31:0]      r_thr_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size   <= RST_CELL_SIZE;
            r_threshold   <= RST_THRESHOLD;
            r_filter_en   <= 1'b1;
            r_keep_static <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CELL_SIZE:   r_cell_size   <= i_cfg_data;
                CFG_THRESHOLD:   r_threshold   <= i_cfg_data;
                CFG_FILTER_EN:   r_filter_en   <= i_cfg_data[0];
                CFG_KEEP_STATIC: r_keep_static <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The squared threshold is recomputed every cycle from the register.
    always_ff @(posedge i_clk) begin
        r_thr_sq <= r_threshold * r_threshold;
    end

    logic [CFG_W-1:0] cs_eff;
    assign cs_eff = (r_cell_size == '0) ? CFG_W'(1) : r_cell_size;

    // Frame state.
    logic               r_bank;
    logic [CNT_W-1:0]   r_hist, r_fill;
    logic [TALLY_W-1:0] r_stat_tally, r_dyn_tally;
    logic               r_ovf;

    // Latched point.
    logic [COORD_W-1:0] r_pos [3];
    logic               r_last;
    logic               r_do_scan;

    // Divider lanes: the dividend register shifts the quotient in from below.
    logic [COORD_W-1:0] r_dvd [3];
    logic [CFG_W-1:0]   r_rem [3];
    logic [DCNT_W-1:0]  r_dcnt;
    logic [COORD_W-1:0] r_cell [3];

    logic [COORD_W-1:0] mag [3];
    logic [CFG_W:0]     rem_sh [3];
    logic               q_bit [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag[k]    = i_s_tdata[k*COORD_W + COORD_W-1] ?
                        (~i_s_tdata[k*COORD_W +: COORD_W] + COORD_W'(1)) :
                        i_s_tdata[k*COORD_W +: COORD_W];
            rem_sh[k] = {r_rem[k], r_dvd[k][COORD_W-1]};
            q_bit[k]  = (rem_sh[k] >= {1'b0, cs_eff});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= i_s_tdata[k*COORD_W +: COORD_W];
                r_dvd[k] <= mag[k];
                r_rem[k] <= '0;
            end
            r_last    <= i_s_tlast;
            r_do_scan <= r_filter_en && (r_hist != '0);
            r_dcnt    <= '0;
        end else if (i_cmd.div_step) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= q_bit[k] ? CFG_W'(rem_sh[k] - {1'b0, cs_eff})
                                     : rem_sh[k][CFG_W-1:0];
                r_dvd[k] <= {r_dvd[k][COORD_W-2:0], q_bit[k]};
            end
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
        // Floor correction: negative with a remainder rounds one further down.
        if (i_cmd.fix) begin
            for (int k = 0; k < 3; k++) begin
                if (!r_pos[k][COORD_W-1]) begin
                    r_cell[k] <= r_dvd[k];
                end else if (r_rem[k] != '0) begin
                    r_cell[k] <= ~r_dvd[k];
                end else begin
                    r_cell[k] <= ~r_dvd[k] + COORD_W'(1);
                end
            end
        end
    end

    // History scan index.
    logic [IDX_W-1:0] r_idx;
    always_ff @(posedge i_clk) begin
        if (i_cmd.fix) begin
            r_idx <= '0;
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Frame store: point coordinates in the low half, cells in the high half.
    logic [ENTRY_W-1:0] rdata, wdata;
    logic               store_we;
    assign store_we = i_cmd.commit && (r_fill != FILL_FULL);
    assign wdata    = {r_cell[2], r_cell[1], r_cell[0], r_pos[2], r_pos[1], r_pos[0]};

    pmc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_D)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr ({r_bank, r_fill[IDX_W-1:0]}),
        .i_wdata (wdata),
        .i_re    (i_cmd.issue),
        .i_raddr ({~r_bank, r_idx}),
        .o_rdata (rdata)
    );

    // Compare pipeline: read, differences, squares, threshold test.
    logic                     r_v1, r_v2, r_v3;
    logic signed [DIFF_W-1:0] r_diff [3];
    logic                     r_near2, r_near3;
    logic [SQ_W-1:0]          r_sq [3];
    logic                     r_hit;

    logic signed [DIFF_W-1:0] dcell [3];
    logic signed [DIFF_W-1:0] dpos [3];
    logic                     near_all;
    logic signed [2*DIFF_W-1:0] prod [3];
    logic [SUM_W-1:0]         dsq;

    always_comb begin
        near_all = 1'b1;
        for (int k = 0; k < 3; k++) begin
            dcell[k] = $signed({r_cell[k][COORD_W-1], r_cell[k]})
                     - $signed({rdata[(k+3)*COORD_W + COORD_W-1],
                                rdata[(k+3)*COORD_W +: COORD_W]});
            dpos[k]  = $signed({r_pos[k][COORD_W-1], r_pos[k]})
                     - $signed({rdata[k*COORD_W + COORD_W-1], rdata[k*COORD_W +: COORD_W]});
            near_all = near_all && (dcell[k] >= -REACH) && (dcell[k] <= REACH);
            prod[k]  = r_diff[k] * r_diff[k];
        end
        dsq = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_diff[k] <= dpos[k];
            r_sq[k]   <= prod[k][SQ_W-1:0];
        end
        r_near2 <= near_all;
        r_near3 <= r_near2;
        if (i_cmd.load) begin
            r_hit <= 1'b0;
        end else if (r_v3 && r_near3 && (dsq < SUM_W'(r_thr_sq))) begin
            r_hit <= 1'b1;
        end
    end

    // Commit: class, tallies, store count and the result register.
    logic               point_static, keep, full, ovf_now;
    logic [TALLY_W-1:0] stat_next, dyn_next;

    assign point_static = !r_do_scan || r_hit;
    assign keep      = !r_filter_en || (point_static == r_keep_static);
    assign full      = (r_fill == FILL_FULL);
    assign ovf_now   = r_ovf || full;
    assign stat_next = (point_static && r_stat_tally != TALLY_MAX) ?
                       r_stat_tally + TALLY_W'(1) : r_stat_tally;
    assign dyn_next  = (!point_static && r_dyn_tally != TALLY_MAX) ?
                       r_dyn_tally + TALLY_W'(1) : r_dyn_tally;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank       <= 1'b0;
            r_hist       <= '0;
            r_fill       <= '0;
            r_stat_tally <= '0;
            r_dyn_tally  <= '0;
            r_ovf        <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_last) begin
                r_bank       <= ~r_bank;
                r_hist       <= full ? r_fill : r_fill + CNT_W'(1);
                r_fill       <= '0;
                r_stat_tally <= '0;
                r_dyn_tally  <= '0;
                r_ovf        <= 1'b0;
            end else begin
                r_fill       <= full ? r_fill : r_fill + CNT_W'(1);
                r_stat_tally <= stat_next;
                r_dyn_tally  <= dyn_next;
                r_ovf        <= ovf_now;
            end
        end
    end

    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= {1'b0, ovf_now, dyn_next, stat_next, point_static, keep,
                           r_pos[2], r_pos[1], r_pos[0]};
            r_out_last <= r_last;
        end
    end

    assign o_m_tdata = r_out_data;
    assign o_m_tlast = r_out_last;

    assign o_sts.div_last  = (r_dcnt == DIV_LAST);
    assign o_sts.do_scan   = r_do_scan;
    assign o_sts.scan_last = ({1'b0, r_idx} == CNT_W'(r_hist - CNT_W'(1)));
    assign o_sts.pipe_busy = r_v1 || r_v2 || r_v3;

endmodule

// ----- rtl/point_motion_classifier.sv -----
// Point motion classifier top level: controller, datapath and assertions.
// A request first runs through a bit-serial cell divider and a floor correction. With history
// present and the filter enabled, each history point is then read in turn on the single
// frame store read port and compared before the result is committed.
// One point is in work at a time; the next request is taken once the result is registered.
// Reset (synchronous, active low) clears configuration to defaults, history and tallies.
`timescale 1ns / 1ps
module point_motion_classifier import pmc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pos_x [19:0], pos_y [39:20], pos_z [59:40], zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_x [19:0], out_y [39:20], out_z [59:40], keep [60], static class [61],
    // static_total [77:62], dynamic_total [93:78], store_overflow [94], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    t_cmd cmd;
    t_sts sts;

    pmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pmc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    // An accepted request makes the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready after accepted request");

    // A commit never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("result overwritten");

    // History reads only happen for points that need a scan.
    a_issue_needs_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> sts.do_scan)
        else $error("history read without scan");

    // Committing never overlaps the compare pipeline.
    a_commit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !sts.pipe_busy)
        else $error("commit while compare pipeline busy");

endmodule
